// ===== rtl/sitda_pkg.sv =====
package sitda_pkg;

    // default for the largest number of digit characters per value
    localparam int MAX_DIGITS_DEF = 10;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // ceil(2^35 / 10): (x * RECIP_10) >> 35 == x / 10 for every 32-bit x
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int          RECIP_SH = 35;

    // microprogram geometry
    localparam int PC_W     = 3;
    localparam int PROG_LEN = 5;

    localparam logic [PC_W-1:0] STEP_FETCH = 3'd0;
    localparam logic [PC_W-1:0] STEP_MUL   = 3'd1;
    localparam logic [PC_W-1:0] STEP_DIV   = 3'd2;
    localparam logic [PC_W-1:0] STEP_SIGN  = 3'd3;
    localparam logic [PC_W-1:0] STEP_DIGIT = 3'd4;

    typedef enum logic [2:0] {
        OP_FETCH,   // wait for an item, load sign and magnitude
        OP_MUL,     // product of magnitude and reciprocal of ten
        OP_DIV,     // quotient and remainder, store one digit
        OP_SIGN,    // emit minus sign when negative
        OP_DIGIT    // emit one stored digit, most significant first
    } t_op;

    typedef enum logic [1:0] {
        C_NEVER,    // always fall through to the next step
        C_MORE,     // more digits to extract
        C_DIG_LEFT  // digits still waiting to be emitted
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic t_uword prog_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_FETCH, cond: C_NEVER, target: STEP_FETCH};
        unique case (pc)
            STEP_FETCH: w = '{op: OP_FETCH, cond: C_NEVER,    target: STEP_FETCH};
            STEP_MUL:   w = '{op: OP_MUL,   cond: C_NEVER,    target: STEP_FETCH};
            STEP_DIV:   w = '{op: OP_DIV,   cond: C_MORE,     target: STEP_MUL};
            STEP_SIGN:  w = '{op: OP_SIGN,  cond: C_NEVER,    target: STEP_FETCH};
            STEP_DIGIT: w = '{op: OP_DIGIT, cond: C_DIG_LEFT, target: STEP_DIGIT};
            default:    w = '{op: OP_FETCH, cond: C_NEVER,    target: STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Converts one signed 32-bit item into its decimal ASCII text, one character
// per output item, most significant digit first: a minus sign for negative
// values, no leading zeros, a single '0' for zero, and o_last set on the final
// character. The most negative value prints as -2147483648. Each digit of a
// value passes the shared divide-by-ten unit (a 32x32 reciprocal multiply,
// then a shift-and-subtract for the remainder); a sign step and one emit
// step per digit follow, most significant digit first. The next item is
// accepted while the last character still waits in the output register.
// Only one item is in flight at a time.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic signed [31:0] i_value,
    // output channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_character,
    output logic              o_last
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // sequencer
    logic [PC_W-1:0]  r_pc, n_pc;
    t_uword           uw;
    logic             step_done;
    logic             cond_true;

    // datapath
    logic             r_neg, n_neg;
    logic [31:0]      r_mag, n_mag;
    logic [63:0]      r_prod, n_prod;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [3:0]       r_dig [MAX_DIGITS];

    // output register
    logic             r_o_valid, n_o_valid;
    logic [7:0]       r_o_char, n_o_char;
    logic             r_o_last, n_o_last;

    // divide step
    logic [28:0]      quot;
    logic [32:0]      quot_x10;
    logic [32:0]      rem_wide;
    logic [3:0]       rem;
    logic [CNT_W-1:0] cnt_inc;
    logic             more_digits;
    logic             dig_wr;
    logic             in_accept;
    logic             out_free;

    assign uw = prog_rom(r_pc);

    assign out_free  = !r_o_valid || !i_stall;
    assign in_accept = i_valid && (uw.op == OP_FETCH);

    // quotient from the registered product, remainder by shift and subtract
    assign quot        = r_prod[63:RECIP_SH];
    assign quot_x10    = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    assign rem_wide    = {1'b0, r_mag} - quot_x10;
    assign rem         = rem_wide[3:0];
    assign cnt_inc     = r_cnt + CNT_W'(1);
    assign more_digits = (quot != 29'd0) && (cnt_inc < CNT_W'(MAX_DIGITS));

    // does the current step finish this cycle
    always_comb begin
        unique case (uw.op)
            OP_FETCH: step_done = i_valid;
            OP_MUL:   step_done = 1'b1;
            OP_DIV:   step_done = 1'b1;
            OP_SIGN:  step_done = !r_neg || out_free;
            OP_DIGIT: step_done = out_free;
            default:  step_done = 1'b1;
        endcase
    end

    // branch condition
    always_comb begin
        case (uw.cond)
            C_NEVER:    cond_true = 1'b0;
            C_MORE:     cond_true = more_digits;
            C_DIG_LEFT: cond_true = (r_idx != IDX_W'(0));
            default:    cond_true = 1'b0;
        endcase
    end

    // step counter: jump when the condition holds, else fall through
    always_comb begin
        n_pc = r_pc;
        if (step_done) begin
            if (cond_true) begin
                n_pc = uw.target;
            end else if (r_pc == PC_W'(PROG_LEN - 1)) begin
                n_pc = STEP_FETCH;
            end else begin
                n_pc = r_pc + PC_W'(1);
            end
        end
    end

    // datapath driven by the control word
    always_comb begin
        n_neg     = r_neg;
        n_mag     = r_mag;
        n_prod    = r_prod;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        dig_wr    = 1'b0;
        n_o_valid = r_o_valid && i_stall;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        unique case (uw.op)
            OP_FETCH: begin
                if (in_accept) begin
                    n_neg = i_value[31];
                    // two's complement negate; the most negative value maps to 2^31
                    n_mag = i_value[31] ? (32'd0 - i_value) : i_value;
                    n_cnt = '0;
                end
            end
            OP_MUL: begin
                n_prod = r_mag * RECIP_10;
            end
            OP_DIV: begin
                dig_wr = 1'b1;
                n_mag  = {3'b000, quot};
                n_cnt  = cnt_inc;
            end
            OP_SIGN: begin
                n_idx = IDX_W'(r_cnt - CNT_W'(1));
                if (r_neg && out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = CHAR_MINUS;
                    n_o_last  = 1'b0;
                end
            end
            OP_DIGIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = CHAR_ZERO + {4'd0, r_dig[r_idx]};
                    n_o_last  = (r_idx == IDX_W'(0));
                    if (r_idx != IDX_W'(0)) begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                end
            end
            default: begin
                n_neg = r_neg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= STEP_FETCH;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
            r_idx     <= '0;
        end else begin
            r_pc      <= n_pc;
            r_o_valid <= n_o_valid;
            r_cnt     <= n_cnt;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_prod   <= n_prod;
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
    end

    // digit store, least significant digit at index zero
    always_ff @(posedge i_clk) begin
        if (dig_wr) begin
            r_dig[r_cnt[IDX_W-1:0]] <= rem;
        end
    end

    assign o_stall     = (uw.op != OP_FETCH);
    assign o_valid     = r_o_valid;
    assign o_character = r_o_char;
    assign o_last      = r_o_last;

    // an accepted item always starts the divide loop
    a_accept_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_pc == STEP_MUL))
        else $error("accepted item did not start the divide loop");

    // digit count stays within the digit store
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CNT_W'(MAX_DIGITS)))
        else $error("digit count beyond the digit store");

    // emit index never points past the extracted digits
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == STEP_DIGIT) |-> ((CNT_W + 1)'(r_idx) < (CNT_W + 1)'(r_cnt)))
        else $error("emit index past the stored digits");

    // a minus sign is never the last character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_character == CHAR_MINUS)) |-> !o_last)
        else $error("minus sign flagged as last");

    // every other character is a decimal digit
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_character != CHAR_MINUS)) |->
        ((o_character >= CHAR_ZERO) && (o_character <= CHAR_ZERO + 8'd9)))
        else $error("character is not a decimal digit");

endmodule

// ===== bench/tb_signed_int_to_decimal_ascii.sv =====
module tb_signed_int_to_decimal_ascii
    import sitda_pkg::*;
();

    // cycles with no handshake on either side before the run is called hung;
    // the longest legal quiet stretch is the receiver hold plus one value
    localparam int IDLE_LIMIT   = 2000;
    // covers the longest value, ten digits, from accept to its last character
    localparam int END_CYCLES   = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 450;
    localparam int BURST_ITEMS  = 30;
    // keep the log readable when something is badly broken
    localparam int MAX_PRINTED  = 50;

    // receiver stall patterns
    localparam int RX_FREE     = 0;
    localparam int RX_LIGHT    = 1;
    localparam int RX_HEAVY    = 2;
    localparam int RX_PERIODIC = 3;

    // one expected character, tagged with the value it came from
    typedef struct {
        logic [7:0]         character;
        logic               last;
        logic signed [31:0] value;
    } t_text_char;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic signed [31:0] i_value = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [7:0]         o_character;
    logic               o_last;

    // characters still owed by the block, oldest first
    t_text_char text_q[$];
    int         errors = 0;

    // sender pacing
    bit tx_gaps_on    = 1'b1;
    int tx_burst_left = 0;

    // receiver pattern state, owned by the receiver process
    int rx_mode   = RX_FREE;
    int rx_left   = 0;
    int rx_phase  = 0;
    int hold_left = 0;
    // long hold requested by a test, picked up by the receiver
    int hold_req  = 0;

    int idle_cycles = 0;

    signed_int_to_decimal_ascii dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_character(o_character),
        .o_last     (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("mismatch: %s", msg);
        end
    endtask

    // decimal text of one value: sign, then digits most significant first,
    // leading zeros dropped, zero prints as a lone '0'
    task automatic queue_decimal_text(input logic signed [31:0] value);
        logic [31:0] mag;
        logic [3:0]  digits [MAX_DIGITS_DEF];
        int          count;
        // magnitude as unsigned, so the most negative value becomes 2^31
        mag   = value[31] ? (~value + 32'd1) : value;
        count = 0;
        if (mag == 32'd0) begin
            text_q.push_back('{CHAR_ZERO, 1'b1, value});
            return;
        end
        // only the low MAX_DIGITS digits survive if the magnitude is wider
        while (mag != 32'd0 && count < MAX_DIGITS_DEF) begin
            digits[count] = 4'(mag % 32'd10);
            mag           = mag / 32'd10;
            count++;
        end
        if (value[31]) begin
            text_q.push_back('{CHAR_MINUS, 1'b0, value});
        end
        for (int k = count - 1; k >= 0; k--) begin
            text_q.push_back('{CHAR_ZERO + 8'(digits[k]), k == 0, value});
        end
    endtask

    // offer one item, hold it until taken, then maybe idle between bursts
    task automatic send_value(input logic signed [31:0] value);
        int gap;
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        queue_decimal_text(value);
        if (tx_gaps_on) begin
            if (tx_burst_left == 0) begin
                tx_burst_left = $urandom_range(30, 1);
                // mostly short gaps, now and then a longer one
                gap = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : $urandom_range(3, 1);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                tx_burst_left--;
            end
        end
    endtask

    // stop offering and wait for every owed character to come out
    task automatic wait_text_drained();
        i_valid <= 1'b0;
        while (text_q.size() != 0) @(posedge i_clk);
    endtask

    // mix of raw 32-bit words, values near zero and values of every length
    function automatic logic signed [31:0] random_value();
        longint      lo;
        longint      hi;
        int          pick;
        int          ndigits;
        logic [31:0] mag;
        pick = $urandom_range(9);
        if (pick < 4) begin
            return $urandom;
        end
        if (pick == 4) begin
            return $signed($urandom_range(40)) - 20;
        end
        ndigits = $urandom_range(10, 1);
        lo      = 1;
        for (int k = 1; k < ndigits; k++) begin
            lo = lo * 10;
        end
        hi = lo * 10 - 1;
        if (hi > 2147483647) begin
            hi = 2147483647;
        end
        mag = $urandom_range(hi, lo);
        return $urandom_range(1) ? -$signed(mag) : $signed(mag);
    endfunction

    // extremes, every digit count, zeros kept inside the digits, both signs
    task automatic test_directed();
        logic signed [31:0] values [$];
        values = '{
            32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
            32'sd100, -32'sd1000, 32'sd10000, 32'sd100000, -32'sd1000000,
            32'sd10000000, 32'sd100000000, 32'sd1000000000, -32'sd1000000001,
            32'sd1234567890, -32'sd987654321, 32'sd2147483647,
            -32'sd2147483647, 32'sh8000_0000, 32'sd1020304050, -32'sd7
        };
        foreach (values[k]) begin
            send_value(values[k]);
        end
        wait_text_drained();
    endtask

    // receiver holds off for a long stretch while items keep coming, so the
    // block fills and has to stall its input
    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        hold_req   = HOLD_CYCLES;
        for (int n = 0; n < BURST_ITEMS; n++) begin
            send_value(random_value());
        end
        tx_gaps_on = 1'b1;
        wait_text_drained();
    endtask

    // random values, with a full pause every hundred items
    task automatic test_random();
        for (int n = 1; n <= RANDOM_ITEMS; n++) begin
            send_value(random_value());
            if (n % 100 == 0) begin
                wait_text_drained();
            end
        end
        wait_text_drained();
    endtask

    // receiver: switches between stall patterns on its own schedule, and
    // honors a long hold when a test asks for one
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_PERIODIC, RX_FREE);
                rx_left = $urandom_range(200, 20);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_LIGHT:    i_stall <= ($urandom_range(99) < 30);
                RX_HEAVY:    i_stall <= ($urandom_range(99) < 75);
                RX_PERIODIC: i_stall <= ((rx_phase % 7) < 3);
                default:     i_stall <= 1'b0;
            endcase
        end
    end

    // every character taken from the block must match the oldest one owed
    always @(posedge i_clk) begin
        t_text_char owed;
        if (i_rst_n && o_valid && !i_stall) begin
            if (text_q.size() == 0) begin
                report_mismatch($sformatf("unexpected character %0d last %b",
                                          o_character, o_last));
            end else begin
                owed = text_q.pop_front();
                if (o_character !== owed.character) begin
                    report_mismatch($sformatf("value %0d: character %0d, want %0d",
                                              owed.value, o_character, owed.character));
                end
                if (o_last !== owed.last) begin
                    report_mismatch($sformatf("value %0d: last %b, want %b",
                                              owed.value, o_last, owed.last));
                end
            end
        end
    end

    // hang detection: nothing moving on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random();

        // let any stray characters show up before the verdict
        repeat (END_CYCLES) @(posedge i_clk);
        if (errors == 0 && text_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
